// ===== hw/rtl/packed_real_offset_remap_table_assert.svh =====
// Assertion macros for the packed/real offset remap table.
// Included by the top level; uses clock and reset of the including module.
`ifndef PACKED_REAL_OFFSET_REMAP_TABLE_ASSERT_SVH
`define PACKED_REAL_OFFSET_REMAP_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/prt_pkg.sv =====
// Shared constants and operation codes for the packed/real offset remap table.
// Depends on nothing; used by the channel interfaces, the top level and the testbench.
`timescale 1ns / 1ps

package prt_pkg;

   localparam int MaxSectionsDef = 16;
   localparam int OffsetBitsDef  = 32;
   localparam int FieldBits      = 32;
   localparam int CountOutBits   = 5;
   localparam int OpBits         = 2;

   typedef enum logic [OpBits-1:0] {
      OP_ADD = 2'd0,
      OP_P2R = 2'd1,
      OP_R2P = 2'd2
   } op_type;

endpackage

// ===== hw/rtl/prt_chan_if.sv =====
// Request and response channel interfaces of the remap table.
// Depends on prt_pkg for field widths.
`timescale 1ns / 1ps

interface prt_req_if;
   logic                         valid;
   logic                         ready;
   logic [prt_pkg::OpBits-1:0]    operation;
   logic [prt_pkg::FieldBits-1:0] real_start;
   logic [prt_pkg::FieldBits-1:0] section_length;
   logic [prt_pkg::FieldBits-1:0] query_offset;

   modport source(output valid, operation, real_start, section_length, query_offset,
                  input ready);
   modport sink(input valid, operation, real_start, section_length, query_offset,
                output ready);
endinterface

interface prt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [prt_pkg::FieldBits-1:0]    translated_offset;
   logic                            hit;
   logic [prt_pkg::FieldBits-1:0]    packed_total;
   logic [prt_pkg::FieldBits-1:0]    real_total;
   logic [prt_pkg::CountOutBits-1:0] count_now;
   logic                            rejected;

   modport source(output valid, translated_offset, hit, packed_total, real_total,
                  count_now, rejected, input ready);
   modport sink(input valid, translated_offset, hit, packed_total, real_total,
                count_now, rejected, output ready);
endinterface

// ===== hw/rtl/packed_real_offset_remap_table.sv =====
// Packed/real offset remap table: a chain of section cells searched in parallel.
// An accepted request word is sampled into the cell match registers; the search state
// then loads the response word into the response register once it is free.
// A new request word is taken only in the idle state, after the search state resolves the first
// hit along the cell chain. Synchronous reset empties the table and clears the totals,
// the control state and the response valid; section contents are not cleared.
`timescale 1ns / 1ps

module packed_real_offset_remap_table #(
   parameter int MAX_SECTIONS = prt_pkg::MaxSectionsDef,
   parameter int OFFSET_BITS  = prt_pkg::OffsetBitsDef
) (
   input logic      clock,
   input logic      reset,
   prt_req_if.sink  req_ch,
   prt_rsp_if.source rsp_ch
);

   `include "packed_real_offset_remap_table_assert.svh"

   localparam int CountBits = $clog2(MAX_SECTIONS + 1);

   typedef enum logic [1:0] {
      S_IDLE   = 2'b01,
      S_SEARCH = 2'b10
   } state_type;

   state_type                 state_ff, state_in;
   logic [CountBits-1:0]      count_ff, count_in;
   logic [OFFSET_BITS-1:0]    packed_total_ff, packed_total_in;
   logic [OFFSET_BITS-1:0]    real_total_ff, real_total_in;
   prt_pkg::op_type           op_ff;
   logic                      rej_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_BITS-1:0]    rsp_value_ff;
   logic                      rsp_hit_ff, rsp_rej_ff;
   logic [OFFSET_BITS-1:0]    rsp_packed_ff, rsp_real_ff;
   logic [CountBits-1:0]      rsp_count_ff;

   logic                      accept, add_op, table_full, add_reject, add_ok, load_rsp;
   logic [OFFSET_BITS-1:0]    in_real, in_length, in_query;
   logic [OFFSET_BITS:0]      end_sum;
   logic                      lookup_op, res_hit;
   logic [OFFSET_BITS-1:0]    res_value;
   logic                      chain_hit [MAX_SECTIONS+1];
   logic [OFFSET_BITS-1:0]    chain_value [MAX_SECTIONS+1];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_real      = OFFSET_BITS'(req_ch.real_start);
   assign in_length    = OFFSET_BITS'(req_ch.section_length);
   assign in_query     = OFFSET_BITS'(req_ch.query_offset);
   assign add_op       = (req_ch.operation == prt_pkg::OP_ADD);
   assign end_sum      = {1'b0, packed_total_ff} + {1'b0, in_length};
   assign table_full   = (count_ff == CountBits'(MAX_SECTIONS));
   assign add_reject   = table_full || end_sum[OFFSET_BITS];
   assign add_ok       = accept && add_op && !add_reject;

   assign chain_hit[0]   = 1'b0;
   assign chain_value[0] = '0;

   for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
      prt_cell #(
         .OFFSET_BITS(OFFSET_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .write_en    (add_ok && (count_ff == CountBits'(i))),
         .write_packed(packed_total_ff),
         .write_real  (in_real),
         .write_length(in_length),
         .sample      (accept),
         .active      (CountBits'(i) < count_ff),
         .dir_p2r     (req_ch.operation == prt_pkg::OP_P2R),
         .query       (in_query),
         .prev_hit    (chain_hit[i]),
         .prev_value  (chain_value[i]),
         .next_hit    (chain_hit[i+1]),
         .next_value  (chain_value[i+1])
      );
   end

   assign lookup_op = (op_ff == prt_pkg::OP_P2R) || (op_ff == prt_pkg::OP_R2P);
   assign res_hit   = lookup_op && chain_hit[MAX_SECTIONS];
   assign res_value = res_hit ? chain_value[MAX_SECTIONS] : '0;
   assign load_rsp  = (state_ff == S_SEARCH) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      packed_total_in = packed_total_ff;
      real_total_in   = real_total_ff;
      rsp_valid_in    = rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (add_ok) begin
         count_in        = count_ff + 1'b1;
         packed_total_in = end_sum[OFFSET_BITS-1:0];
         real_total_in   = in_real + in_length;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         packed_total_ff <= '0;
         real_total_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         packed_total_ff <= packed_total_in;
         real_total_ff   <= real_total_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= prt_pkg::op_type'(req_ch.operation);
         rej_ff <= add_op && add_reject;
      end
      if (load_rsp) begin
         rsp_value_ff  <= res_value;
         rsp_hit_ff    <= res_hit;
         rsp_rej_ff    <= rej_ff;
         rsp_packed_ff <= packed_total_ff;
         rsp_real_ff   <= real_total_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.translated_offset = prt_pkg::FieldBits'(rsp_value_ff);
   assign rsp_ch.hit               = rsp_hit_ff;
   assign rsp_ch.packed_total      = prt_pkg::FieldBits'(rsp_packed_ff);
   assign rsp_ch.real_total        = prt_pkg::FieldBits'(rsp_real_ff);
   assign rsp_ch.count_now         = prt_pkg::CountOutBits'(rsp_count_ff);
   assign rsp_ch.rejected          = rsp_rej_ff;

   `PRT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CountBits'(MAX_SECTIONS),
      "section count exceeds table depth")
   `PRT_ASSERT_NEXT(a_add_grows, add_ok, count_ff == $past(count_ff) + 1'b1,
      "accepted add did not grow the table")
   `PRT_ASSERT_NOW(a_hit_not_rej, rsp_valid_ff && rsp_hit_ff, !rsp_rej_ff,
      "response word both hit and rejected")

endmodule

// ===== hw/rtl/prt_cell.sv =====
// One section cell of the remap table: holds a section, tests the query against it
// and passes the first hit down the chain. Depends on no package.
`timescale 1ns / 1ps

module prt_cell #(
   parameter int OFFSET_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   write_en,
   input  logic [OFFSET_BITS-1:0] write_packed,
   input  logic [OFFSET_BITS-1:0] write_real,
   input  logic [OFFSET_BITS-1:0] write_length,
   input  logic                   sample,
   input  logic                   active,
   input  logic                   dir_p2r,
   input  logic [OFFSET_BITS-1:0] query,
   input  logic                   prev_hit,
   input  logic [OFFSET_BITS-1:0] prev_value,
   output logic                   next_hit,
   output logic [OFFSET_BITS-1:0] next_value
);

   logic [OFFSET_BITS-1:0] packed_ff, real_ff, length_ff;
   logic [OFFSET_BITS-1:0] from_start, to_start, delta;
   logic                   match_ff, match_in;
   logic [OFFSET_BITS-1:0] xlat_ff, xlat_in;

   always_comb begin
      from_start = dir_p2r ? packed_ff : real_ff;
      to_start   = dir_p2r ? real_ff : packed_ff;
      delta      = query - from_start;
      match_in   = active && (query >= from_start) && (delta < length_ff);
      xlat_in    = to_start + delta;
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         packed_ff <= write_packed;
         real_ff   <= write_real;
         length_ff <= write_length;
      end
      if (sample) begin
         xlat_ff <= xlat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (sample) begin
         match_ff <= match_in;
      end
   end

   assign next_hit   = prev_hit || match_ff;
   assign next_value = prev_hit ? prev_value : (match_ff ? xlat_ff : '0);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the packed/real offset remap table.
// Drives prt_req_if and checks prt_rsp_if against a scoreboard that mirrors the section table.
// Depends on prt_pkg, prt_chan_if.sv and the packed_real_offset_remap_table top level.
`timescale 1ns / 1ps

typedef struct packed {
   logic [31:0] translated_offset;
   logic        hit;
   logic [31:0] packed_total;
   logic [31:0] real_total;
   logic [4:0]  count_now;
   logic        rejected;
} remap_answer_type;

localparam logic [1:0] OP_UNUSED = 2'd3;

class remap_scoreboard;
   localparam int Depth = prt_pkg::MaxSectionsDef;

   logic [31:0]      pk_start[Depth];
   logic [31:0]      rl_start[Depth];
   logic [31:0]      span[Depth];
   int unsigned      sections;
   remap_answer_type answers[$];
   int unsigned      errors, checked, adds, refused, lookups, hits;

   function new();
      sections = 0;
      errors   = 0;
      checked  = 0;
      adds     = 0;
      refused  = 0;
      lookups  = 0;
      hits     = 0;
   endfunction

   function logic [31:0] packed_total();
      if (sections == 0) return 32'd0;
      return pk_start[sections-1] + span[sections-1];
   endfunction

   function logic [31:0] real_total();
      if (sections == 0) return 32'd0;
      return rl_start[sections-1] + span[sections-1];
   endfunction

   function void note_request(logic [1:0] op, logic [31:0] rs, logic [31:0] len,
                              logic [31:0] q);
      remap_answer_type a;
      logic [31:0]      base, from, to;
      int unsigned      i;
      a = '0;
      if (op == prt_pkg::OP_ADD) begin
         adds++;
         base = packed_total();
         if (sections >= Depth || len > ~base) begin
            a.rejected = 1'b1;
            refused++;
         end else begin
            pk_start[sections] = base;
            rl_start[sections] = rs;
            span[sections]     = len;
            sections++;
         end
      end else if (op == prt_pkg::OP_P2R || op == prt_pkg::OP_R2P) begin
         lookups++;
         for (i = 0; i < sections && !a.hit; i++) begin
            from = (op == prt_pkg::OP_P2R) ? pk_start[i] : rl_start[i];
            to   = (op == prt_pkg::OP_P2R) ? rl_start[i] : pk_start[i];
            if (q >= from && (q - from) < span[i]) begin
               a.translated_offset = to + (q - from);
               a.hit = 1'b1;
            end
         end
         if (a.hit) hits++;
      end
      a.packed_total = packed_total();
      a.real_total   = real_total();
      a.count_now    = sections[4:0];
      answers.insert(answers.size(), a);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      end
   endfunction

   function void check_result(remap_answer_type got);
      remap_answer_type want;
      checked++;
      if (answers.size() == 0) begin
         errors++;
         if (errors <= 40)
            $display("%0t: response word with nothing expected, expected none, actual %h",
                     $time, got);
         return;
      end
      want = answers.pop_front();
      compare_field("translated_offset", want.translated_offset, got.translated_offset);
      compare_field("hit", {31'd0, want.hit}, {31'd0, got.hit});
      compare_field("packed_total", want.packed_total, got.packed_total);
      compare_field("real_total", want.real_total, got.real_total);
      compare_field("count_now", {27'd0, want.count_now}, {27'd0, got.count_now});
      compare_field("rejected", {31'd0, want.rejected}, {31'd0, got.rejected});
   endfunction
endclass

module testbench;
   localparam int RandomWords = 1230;
   localparam int IdleLimit   = 3000;
   localparam int HoldCycles  = 400;

   logic clock;
   logic reset;
   bit   steady;
   bit   hold_off;

   prt_req_if req_ch();
   prt_rsp_if rsp_ch();

   remap_scoreboard board = new();

   packed_real_offset_remap_table dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_word(input logic [1:0] op, input logic [31:0] rs,
                            input logic [31:0] len, input logic [31:0] q);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.operation      <= op;
      req_ch.real_start     <= rs;
      req_ch.section_length <= len;
      req_ch.query_offset   <= q;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(op, rs, len, q);
   endtask

   task automatic send_random_word();
      int unsigned roll, kind, place, k;
      logic [1:0]  op;
      logic [31:0] rs, len, q, base, from, spn;
      roll = $urandom_range(0, 99);
      rs   = $urandom;
      len  = $urandom;
      q    = $urandom;
      op   = prt_pkg::OP_P2R;
      if (roll < 3) begin
         op = OP_UNUSED;
      end else if (roll < 6) begin
         op   = prt_pkg::OP_ADD;
         base = board.packed_total();
         kind = $urandom_range(0, 9);
         if (kind < 3 && board.sections > 0) begin
            k  = $urandom_range(0, board.sections - 1);
            rs = board.rl_start[k] + $urandom_range(0, 255);
         end
         if (board.sections == prt_pkg::MaxSectionsDef - 1)
            len = ~base;
         else if (kind == 9)
            len = 32'd0;
         else if (kind >= 7)
            len = ~base + $urandom_range(1, 255);
         else
            len = $urandom_range(1, 65536);
      end else if (roll < 15 || board.sections == 0) begin
         op = $urandom_range(0, 1) ? prt_pkg::OP_P2R : prt_pkg::OP_R2P;
      end else begin
         k    = $urandom_range(0, board.sections - 1);
         op   = $urandom_range(0, 1) ? prt_pkg::OP_P2R : prt_pkg::OP_R2P;
         from = (op == prt_pkg::OP_P2R) ? board.pk_start[k] : board.rl_start[k];
         spn  = board.span[k];
         place = $urandom_range(0, 9);
         case (place)
            6: q = from;
            7: q = from + spn - 32'd1;
            8: q = from + spn;
            9: q = from - 32'd1;
            default: q = from + ((spn == 0) ? 32'd0 : ($urandom % spn));
         endcase
      end
      send_word(op, rs, len, q);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result({rsp_ch.translated_offset, rsp_ch.hit, rsp_ch.packed_total,
                             rsp_ch.real_total, rsp_ch.count_now, rsp_ch.rejected});
   end

   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off) begin
            rsp_ch.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_off = 1'b0;
         end
         stall = steady ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no word moved for %0d cycles.", IdleLimit);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int unsigned n;
      steady   = 1'b0;
      hold_off = 1'b0;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.operation      <= prt_pkg::OP_ADD;
      req_ch.real_start     <= '0;
      req_ch.section_length <= '0;
      req_ch.query_offset   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table, then a plain section, one whose real range passes the top of
      // the offset space, a zero-length section and an add that overflows.
      send_word(prt_pkg::OP_P2R, 32'd0, 32'd0, 32'd0);
      send_word(prt_pkg::OP_R2P, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_word(OP_UNUSED, 32'd0, 32'd0, 32'd0);
      send_word(prt_pkg::OP_ADD, 32'h0000_1000, 32'h0000_0400, 32'd0);
      send_word(prt_pkg::OP_ADD, 32'hFFFF_FF00, 32'h0000_0200, 32'd0);
      send_word(prt_pkg::OP_ADD, 32'h0000_5000, 32'd0, 32'd0);
      send_word(prt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(prt_pkg::OP_P2R, 32'd0, 32'd0, 32'h0000_0000);
      send_word(prt_pkg::OP_P2R, 32'd0, 32'd0, 32'h0000_03FF);
      send_word(prt_pkg::OP_P2R, 32'd0, 32'd0, 32'h0000_0400);
      send_word(prt_pkg::OP_P2R, 32'd0, 32'd0, 32'h0000_05FF);
      send_word(prt_pkg::OP_P2R, 32'd0, 32'd0, 32'h0000_0600);
      send_word(prt_pkg::OP_R2P, 32'd0, 32'd0, 32'h0000_5000);
      send_word(prt_pkg::OP_R2P, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_word(prt_pkg::OP_R2P, 32'd0, 32'd0, 32'h0000_0010);
      send_word(prt_pkg::OP_R2P, 32'd0, 32'd0, 32'h0000_1000);
      send_word(prt_pkg::OP_R2P, 32'd0, 32'd0, 32'h0000_1400);
      send_word(prt_pkg::OP_P2R, 32'd0, 32'd0, 32'hFFFF_FFFF);
      send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // Overlapping real range: the earlier section must win.
      send_word(prt_pkg::OP_ADD, 32'h0000_1200, 32'h0000_0100, 32'd0);
      send_word(prt_pkg::OP_R2P, 32'd0, 32'd0, 32'h0000_1250);
      send_word(prt_pkg::OP_P2R, 32'd0, 32'd0, 32'h0000_0650);

      for (n = 0; n < RandomWords; n++) begin
         if (n == 300)
            hold_off = 1'b1;
         if (n == 600) begin
            req_ch.valid <= 1'b0;
            while (board.answers.size() != 0) @(posedge clock);
         end
         steady = (n >= 800 && n < 1000);
         send_random_word();
      end
      steady = 1'b0;

      req_ch.valid <= 1'b0;
      while (board.answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d adds (%0d refused) and %0d lookups (%0d hits); %0d responses checked.",
               board.adds, board.refused, board.lookups, board.hits, board.checked);
      $display("Table ended with %0d sections, packed total %h.",
               board.sections, board.packed_total());
      if (board.errors == 0 && board.answers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
